// ----- hw/rtl/gtd_pkg.sv -----
// shared types and constants for the goertzel tone detector
package gtd_pkg;

   localparam int SampleW    = 16;
   localparam int CoeffW     = 16;
   localparam int DelayW     = 32;
   localparam int ProdW      = DelayW + CoeffW;
   localparam int OutW       = 16;
   localparam int CountBits  = 16;
   localparam int CmpW       = (CountBits + 1 > 16) ? CountBits + 1 : 16;
   localparam int CsrIndexW  = 2;
   localparam int CsrDataW   = 16;
   localparam int LoopShift  = 14;
   localparam int FfShift    = 15;
   localparam int OutShift   = 10;
   localparam int BlockLenRst = 256;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_FEEDBACK_COEFF = 2'd0,
      CSR_FF_COEFF_REAL  = 2'd1,
      CSR_FF_COEFF_IMAG  = 2'd2,
      CSR_BLOCK_LENGTH   = 2'd3
   } csr_index_type;

   // delay line snapshot at the end of a block
   typedef struct packed {
      logic signed [DelayW-1:0] w0;
      logic signed [DelayW-1:0] w1;
   } bin_state_type;

   typedef struct packed {
      logic signed [CoeffW-1:0] ff_real;
      logic signed [CoeffW-1:0] ff_imag;
   } ff_coeff_type;

endpackage

// ----- hw/rtl/goertzel_tone_detector_unit.sv -----
// top level of the goertzel tone detector: register file, front, queue and back
// one sample at a time: full stays high through the one multiply and one add of the recurrence
// end of block: the front then runs a zero-input pass and the queue transfer, which waits while the queue is full
// back end: one result at a time, through the 16-step square root; it overlaps the next block
// synchronous reset clears delay line, count, queue and result; coeffs 0, length 256
module goertzel_tone_detector_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample channel
   input  logic                                  push,
   output logic                                  full,
   input  logic signed [gtd_pkg::SampleW-1:0]    req_sample,
   // result channel
   output logic                                  empty,
   input  logic                                  pop,
   output logic signed [gtd_pkg::OutW-1:0]       rsp_bin_real,
   output logic signed [gtd_pkg::OutW-1:0]       rsp_bin_imag,
   output logic        [gtd_pkg::OutW-1:0]       rsp_bin_magnitude,
   // register write port
   input  logic                                  csr_write_enable,
   input  logic        [gtd_pkg::CsrIndexW-1:0]  csr_index,
   input  logic        [gtd_pkg::CsrDataW-1:0]   csr_wdata
);
   import gtd_pkg::*;

   // configuration registers
   logic signed [CoeffW-1:0] fb_coeff_ff;
   logic signed [CoeffW-1:0] ff_real_ff;
   logic signed [CoeffW-1:0] ff_imag_ff;
   logic        [CoeffW-1:0] block_len_ff;

   // front to back queue
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;
   bin_state_type q_push_data;
   bin_state_type q_head;
   ff_coeff_type  coeffs;

   // writes must only land while the block is idle (the user's duty, not enforced here), so no shadowing is needed
   always_ff @(posedge clock) begin
      if (reset) begin
         fb_coeff_ff  <= '0;
         ff_real_ff   <= '0;
         ff_imag_ff   <= '0;
         block_len_ff <= CoeffW'(BlockLenRst);
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_FEEDBACK_COEFF: fb_coeff_ff  <= csr_wdata;
            CSR_FF_COEFF_REAL:  ff_real_ff   <= csr_wdata;
            CSR_FF_COEFF_IMAG:  ff_imag_ff   <= csr_wdata;
            CSR_BLOCK_LENGTH:   block_len_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign coeffs = '{ff_real: ff_real_ff, ff_imag: ff_imag_ff};

   // sample intake and recurrence; full stays high while a sample is in flight
   gtd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .sample         (req_sample),
      .feedback_coeff (fb_coeff_ff),
      .block_length   (block_len_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_push_data)
   );

   // decouples the recurrence from the slow end-of-block work
   gtd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // feed-forward, magnitude and the result register that the consumer pops
   gtd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .coeffs        (coeffs),
      .empty         (empty),
      .pop           (pop),
      .bin_real      (rsp_bin_real),
      .bin_imag      (rsp_bin_imag),
      .bin_magnitude (rsp_bin_magnitude)
   );

endmodule

// ----- hw/rtl/gtd_queue.sv -----
// two-entry queue carrying end-of-block delay line state from front to back
module gtd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  gtd_pkg::bin_state_type push_data,
   output logic                   full,
   input  logic                   pop,
   output gtd_pkg::bin_state_type head,
   output logic                   empty
);
   import gtd_pkg::*;

   logic [1:0]    count_ff, count_in;
   bin_state_type slot0_ff, slot0_in;
   bin_state_type slot1_ff, slot1_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot0_ff;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push && pop) begin
         if (count_ff == 2'd1) begin
            slot0_in = push_data;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_data;
         end
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
         count_in = count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ----- hw/rtl/gtd_front.sv -----
// sample intake, block counting and goertzel recurrence
module gtd_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic signed [gtd_pkg::SampleW-1:0]    sample,
   input  logic signed [gtd_pkg::CoeffW-1:0]     feedback_coeff,
   input  logic        [gtd_pkg::CoeffW-1:0]     block_length,
   input  logic                                  q_full,
   output logic                                  q_push,
   output gtd_pkg::bin_state_type                q_data
);
   import gtd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_PUSH
   } state_type;

   state_type                state_ff, state_in;
   logic [CountBits-1:0]     count_ff, count_in;
   logic signed [DelayW-1:0] d1_ff, d1_in;
   logic signed [DelayW-1:0] d2_ff, d2_in;
   logic signed [SampleW-1:0] x_ff, x_in;
   logic signed [ProdW-1:0]  prod_ff, prod_in;
   logic                     last_ff, last_in;
   logic                     flush_ff, flush_in;

   logic [CountBits:0]       next_count;
   logic                     block_end;
   logic [ProdW-1:0]         rounded;
   logic [DelayW-1:0]        w0;

   // block ends at the length or when the counter would wrap
   assign next_count = {1'b0, count_ff} + {{CountBits{1'b0}}, 1'b1};
   assign block_end  = (CmpW'(next_count) >= CmpW'(block_length)) || next_count[CountBits];

   assign rounded = prod_ff + ProdW'(1 << (LoopShift - 1));
   assign w0      = rounded[LoopShift +: DelayW] + DelayW'(x_ff) - d2_ff;

   assign full   = (state_ff != ST_IDLE);
   assign q_push = (state_ff == ST_PUSH) && !q_full;
   assign q_data = '{w0: d1_ff, w1: d2_ff};

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      d1_in    = d1_ff;
      d2_in    = d2_ff;
      x_in     = x_ff;
      prod_in  = prod_ff;
      last_in  = last_ff;
      flush_in = flush_ff;
      case (state_ff)
         ST_IDLE: begin
            if (push) begin
               x_in     = sample;
               last_in  = block_end;
               count_in = block_end ? '0 : next_count[CountBits-1:0];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = d1_ff * feedback_coeff;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            d2_in = d1_ff;
            d1_in = w0;
            if (flush_ff) begin
               state_in = ST_PUSH;
            end else if (last_ff) begin
               // extra zero-input pass
               last_in  = 1'b0;
               flush_in = 1'b1;
               x_in     = '0;
               state_in = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PUSH: begin
            if (!q_full) begin
               d1_in    = '0;
               d2_in    = '0;
               flush_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         d1_ff    <= '0;
         d2_ff    <= '0;
         last_ff  <= 1'b0;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
         last_ff  <= last_in;
         flush_ff <= flush_in;
      end
      x_ff    <= x_in;
      prod_ff <= prod_in;
   end

endmodule

// ----- hw/rtl/gtd_back.sv -----
// feed-forward step, magnitude square root and result register
module gtd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  gtd_pkg::bin_state_type             q_head,
   output logic                               q_pop,
   input  gtd_pkg::ff_coeff_type              coeffs,
   output logic                               empty,
   input  logic                               pop,
   output logic signed [gtd_pkg::OutW-1:0]    bin_real,
   output logic signed [gtd_pkg::OutW-1:0]    bin_imag,
   output logic        [gtd_pkg::OutW-1:0]    bin_magnitude
);
   import gtd_pkg::*;

   localparam int RootW  = OutW;
   localparam int RemW   = RootW + 4;
   localparam int RadW   = 2 * RootW;
   localparam int KeepW  = OutW + OutShift;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_RE,
      ST_MUL_IM,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_SUM,
      ST_SQRT,
      ST_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic signed [DelayW-1:0]  w0_ff, w0_in;
   logic signed [DelayW-1:0]  w1_ff, w1_in;
   logic signed [ProdW-1:0]   prod_ff, prod_in;
   logic signed [OutW-1:0]    re_ff, re_in;
   logic signed [OutW-1:0]    im_ff, im_in;
   logic [RadW-1:0]           sq_ff, sq_in;
   logic [RadW-1:0]           acc_ff, acc_in;
   logic [RadW-1:0]           rad_ff, rad_in;
   logic [RemW-1:0]           rem_ff, rem_in;
   logic [RootW-1:0]          root_ff, root_in;
   logic [3:0]                step_ff, step_in;
   logic                      out_valid_ff, out_valid_in;
   logic signed [OutW-1:0]    out_re_ff, out_re_in;
   logic signed [OutW-1:0]    out_im_ff, out_im_in;
   logic [OutW-1:0]           out_mag_ff, out_mag_in;

   logic signed [CoeffW-1:0]  coef_sel;
   logic [ProdW-1:0]          prod_rnd;
   logic [KeepW-1:0]          re_sum;
   logic [KeepW-1:0]          im_sum;
   logic [RemW-1:0]           rem_shift;
   logic [RemW-1:0]           trial;
   logic                      out_free;

   assign coef_sel = (state_ff == ST_MUL_RE) ? coeffs.ff_real : coeffs.ff_imag;
   assign prod_rnd = prod_ff + ProdW'(1 << (FfShift - 1));
   // only the low bits survive the final truncation, so keep the sums narrow
   assign re_sum = w0_ff[KeepW-1:0] + prod_rnd[FfShift +: KeepW]
                   + KeepW'(1 << (OutShift - 1));
   assign im_sum = prod_rnd[FfShift +: KeepW] + KeepW'(1 << (OutShift - 1));

   // one result bit per step of the square root
   assign rem_shift = {rem_ff[RemW-3:0], rad_ff[RadW-1 -: 2]};
   assign trial     = {2'b00, root_ff, 2'b01};

   assign out_free = !out_valid_ff || pop;
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;

   assign empty         = !out_valid_ff;
   assign bin_real      = out_re_ff;
   assign bin_imag      = out_im_ff;
   assign bin_magnitude = out_mag_ff;

   always_comb begin
      state_in     = state_ff;
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      prod_in      = prod_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !pop;
      out_re_in    = out_re_ff;
      out_im_in    = out_im_ff;
      out_mag_in   = out_mag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               w0_in    = q_head.w0;
               w1_in    = q_head.w1;
               state_in = ST_MUL_RE;
            end
         end
         ST_MUL_RE: begin
            prod_in  = coef_sel * w1_ff;
            state_in = ST_MUL_IM;
         end
         ST_MUL_IM: begin
            re_in    = re_sum[OutShift +: OutW];
            prod_in  = coef_sel * w1_ff;
            state_in = ST_SQ_RE;
         end
         ST_SQ_RE: begin
            im_in    = im_sum[OutShift +: OutW];
            sq_in    = RadW'(re_ff * re_ff);
            state_in = ST_SQ_IM;
         end
         ST_SQ_IM: begin
            acc_in   = sq_ff;
            sq_in    = RadW'(im_ff * im_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rad_in   = acc_ff + sq_ff;
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (rem_shift >= trial) begin
               rem_in  = rem_shift - trial;
               root_in = {root_ff[RootW-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               root_in = {root_ff[RootW-2:0], 1'b0};
            end
            rad_in  = {rad_ff[RadW-3:0], 2'b00};
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(RootW - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_re_in    = re_ff;
               out_im_in    = im_ff;
               // round up when the remainder exceeds the root
               out_mag_in   = root_ff + {{(RootW-1){1'b0}}, (rem_ff > RemW'(root_ff))};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
      w0_ff      <= w0_in;
      w1_ff      <= w1_in;
      prod_ff    <= prod_in;
      re_ff      <= re_in;
      im_ff      <= im_in;
      sq_ff      <= sq_in;
      acc_ff     <= acc_in;
      rad_ff     <= rad_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      out_re_ff  <= out_re_in;
      out_im_ff  <= out_im_in;
      out_mag_ff <= out_mag_in;
   end

endmodule
